// ===== design/frame_history_nearest_lookup_unit_assert.svh =====
// Assertion helpers for the frame history lookup unit.
// Both expect clk and rst_n in scope.
`ifndef FRAME_HISTORY_NEAREST_LOOKUP_UNIT_ASSERT_SVH
`define FRAME_HISTORY_NEAREST_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication
`define FHNL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fhnl: same-cycle check failed");

// next-cycle implication
`define FHNL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fhnl: next-cycle check failed");

`endif

// ===== design/fhnl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fhnl_pkg;

    localparam int FRAME_ID_W = 48;
    localparam int TS_W       = 48;
    localparam int HANDLE_W   = 32;
    localparam int CHAN_W     = 4;
    localparam int MD_W       = 4;
    localparam int GAP_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int DEPTH_DEF        = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 1'd1;

    // item kinds
    localparam logic KIND_STORE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [FRAME_ID_W-1:0] frame_num;
        logic [TS_W-1:0]       capture_time;
        logic [HANDLE_W-1:0]   image_handle;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/fhnl_entry_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// History entry RAM: one write port, one registered read port.
module fhnl_entry_mem #(
    parameter int WORDS  = 128,
    parameter int ADDR_W = 7
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire fhnl_pkg::entry_t     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output fhnl_pkg::entry_t          rd_data
);
    import fhnl_pkg::*;

    entry_t mem [WORDS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/fhnl_meta_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-channel count and oldest slot. RAM plus one valid bit per channel;
// a channel never written reads as empty.
module fhnl_meta_store #(
    parameter int NUM_CHANNELS = 16,
    parameter int CH_W         = 4,
    parameter int CNT_W        = 4,
    parameter int PTR_W        = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [CH_W-1:0]  rd_addr,
    output logic      [CNT_W-1:0] rd_cnt,
    output logic      [PTR_W-1:0] rd_oldest,
    input  wire logic             wr_en,
    input  wire logic [CH_W-1:0]  wr_addr,
    input  wire logic [CNT_W-1:0] wr_cnt,
    input  wire logic [PTR_W-1:0] wr_oldest
);

    logic [CNT_W+PTR_W-1:0] mem [NUM_CHANNELS];
    logic [CNT_W+PTR_W-1:0] rd_q_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_cnt, wr_oldest};
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_cnt    = rd_valid_reg ? rd_q_reg[CNT_W+PTR_W-1:PTR_W] : '0;
    assign rd_oldest = rd_valid_reg ? rd_q_reg[PTR_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== design/frame_history_nearest_lookup_unit.sv =====
// Frame history with nearest-frame lookup, one ring of DEPTH slots per channel.
// Input channel (in_valid/in_ready): one transaction is a store (kind 0) or a
// lookup (kind 1). A store with image_valid set on an existing channel appends
// the frame and trims the ring to the depth limit; it gives no result. A lookup
// gives exactly one result transaction on the output channel
// (out_valid/out_ready): found plus the chosen entry, or all zero on a miss.
// A store reads the metadata, then writes it back together with the entry. A
// lookup reads the metadata, then reads the channel's live entries oldest to
// newest, one entry RAM read per cycle (single registered read port), then does
// the gap check in its final step before out_valid.
// One item is in flight at a time; in_ready is high only between items, so a
// new item is not taken until the last one is through.
// The output register holds a finished result while the receiver stalls; the
// next item is still accepted, and a later lookup waits in its last step
// until the register is free.
// Reset: every channel reads as empty at once (per-channel valid bits), no
// clearing pass; the depth limit returns to DEPTH and the gap limit to 1.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at once.
`timescale 1ns / 1ps
`default_nettype none

`include "frame_history_nearest_lookup_unit_assert.svh"

module frame_history_nearest_lookup_unit #(
    parameter int NUM_CHANNELS = fhnl_pkg::NUM_CHANNELS_DEF,
    parameter int DEPTH        = fhnl_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [fhnl_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [fhnl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              kind,
    input  wire logic [fhnl_pkg::CHAN_W-1:0]       channel,
    input  wire logic [fhnl_pkg::FRAME_ID_W-1:0]   frame_num,
    input  wire logic [fhnl_pkg::TS_W-1:0]         capture_time,
    input  wire logic [fhnl_pkg::HANDLE_W-1:0]     image_handle,
    input  wire logic                              image_valid,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   found,
    output logic      [fhnl_pkg::FRAME_ID_W-1:0]   hit_frame_num,
    output logic      [fhnl_pkg::TS_W-1:0]         hit_capture_time,
    output logic      [fhnl_pkg::HANDLE_W-1:0]     hit_image_handle
);
    import fhnl_pkg::*;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int WORDS  = NUM_CHANNELS * DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CMP_W  = 9;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_META = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    // ring slot + 1 with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ring slot sum, known to stay below 2*DEPTH
    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [SUM_W-1:0] s);
        ptr_wrap = (s >= SUM_W'(DEPTH)) ? PTR_W'(s - SUM_W'(DEPTH)) : PTR_W'(s);
    endfunction

    // control
    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]      md_reg, md_next;
    logic [GAP_W-1:0]      gap_reg, gap_next;
    logic                  have_reg, have_next;
    logic                  exact_reg, exact_next;

    // captured transaction and scan datapath
    logic                  kind_reg;
    logic                  chan_ok_reg;
    logic                  img_valid_reg;
    logic [CH_W-1:0]       chan_reg;
    logic [ADDR_W-1:0]     base_reg;
    logic [FRAME_ID_W-1:0] fid_reg;
    logic [TS_W-1:0]       ts_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic [CNT_W-1:0]      proc_reg, proc_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    entry_t                best_reg, best_next;

    // output payload
    logic                  found_reg, found_next;
    entry_t                hit_reg, hit_next;

    logic                  in_accept;
    logic                  chan_ok_in;
    logic [CH_W-1:0]       chan_idx_in;

    // metadata RAM
    logic [CNT_W-1:0]      meta_cnt;
    logic [PTR_W-1:0]      meta_old;
    logic                  meta_wr_en;
    logic [CNT_W-1:0]      meta_wr_cnt;
    logic [PTR_W-1:0]      meta_wr_old;

    // entry RAM
    logic                  ent_wr_en;
    logic [ADDR_W-1:0]     ent_wr_addr;
    entry_t                ent_wr_data;
    logic                  ent_rd_en;
    logic [ADDR_W-1:0]     ent_rd_addr;
    entry_t                ent_rd_data;

    // store bookkeeping
    logic                  st_full;
    logic [CNT_W-1:0]      st_cnt1;
    logic [PTR_W-1:0]      st_old1;
    logic [PTR_W-1:0]      st_slot;
    logic [CNT_W-1:0]      st_cnt2;
    logic [CNT_W-1:0]      st_drop;

    // final check
    logic [FRAME_ID_W-1:0] gap_diff;
    logic                  gap_ok;
    logic                  fin_found;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign chan_ok_in  = CMP_W'(channel) < CMP_W'(NUM_CHANNELS);
    assign chan_idx_in = CH_W'(channel);

    fhnl_meta_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_W         (CH_W),
        .CNT_W        (CNT_W),
        .PTR_W        (PTR_W)
    ) u_meta (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept && chan_ok_in),
        .rd_addr   (chan_idx_in),
        .rd_cnt    (meta_cnt),
        .rd_oldest (meta_old),
        .wr_en     (meta_wr_en),
        .wr_addr   (chan_reg),
        .wr_cnt    (meta_wr_cnt),
        .wr_oldest (meta_wr_old)
    );

    fhnl_entry_mem #(
        .WORDS  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // Store: drop one if the ring is full, append at oldest + count, then
    // trim down to the depth limit by advancing the oldest slot.
    always_comb
    begin
        st_full = (meta_cnt == CNT_W'(DEPTH));
        st_cnt1 = st_full ? meta_cnt - 1'b1 : meta_cnt;
        st_old1 = st_full ? ptr_inc(meta_old) : meta_old;
        st_slot = ptr_wrap(SUM_W'(st_old1) + SUM_W'(st_cnt1));
        st_cnt2 = st_cnt1 + 1'b1;
        st_drop = (st_cnt2 > md_reg) ? st_cnt2 - md_reg : '0;
        meta_wr_cnt = (st_cnt2 > md_reg) ? md_reg : st_cnt2;
        meta_wr_old = ptr_wrap(SUM_W'(st_old1) + SUM_W'(st_drop));
        ent_wr_addr = base_reg + ADDR_W'(st_slot);
        ent_wr_data = '{frame_num: fid_reg, capture_time: ts_reg, image_handle: handle_reg};
    end

    // inexact matches must lie within the gap limit of the target
    assign gap_diff  = fid_reg - best_reg.frame_num;
    assign gap_ok    = exact_reg || (gap_diff <= FRAME_ID_W'(gap_reg));
    assign fin_found = have_reg && gap_ok;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        md_next        = md_reg;
        gap_next       = gap_reg;
        have_next      = have_reg;
        exact_next     = exact_reg;
        cnt_next       = cnt_reg;
        iss_next       = iss_reg;
        proc_next      = proc_reg;
        ptr_next       = ptr_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        meta_wr_en     = 1'b0;
        ent_wr_en      = 1'b0;
        ent_rd_en      = 1'b0;
        ent_rd_addr    = base_reg + ADDR_W'(ptr_reg);

        if (cfg_wr_en)
        begin
            if (cfg_addr == REG_DEPTH_LIMIT)
            begin
                if (cfg_wdata[MD_W-1:0] == '0)
                begin
                    md_next = CNT_W'(1);
                end
                else if (32'(cfg_wdata[MD_W-1:0]) > 32'(DEPTH))
                begin
                    md_next = CNT_W'(DEPTH);
                end
                else
                begin
                    md_next = CNT_W'(cfg_wdata[MD_W-1:0]);
                end
            end
            else if (cfg_addr == REG_GAP_LIMIT)
            begin
                gap_next = (cfg_wdata[GAP_W-1:0] == '0) ? GAP_W'(1) : cfg_wdata[GAP_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                unique case (kind_reg)
                    KIND_STORE:
                    begin
                        if (chan_ok_reg && img_valid_reg)
                        begin
                            meta_wr_en = 1'b1;
                            ent_wr_en  = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    KIND_LOOKUP:
                    begin
                        have_next  = 1'b0;
                        exact_next = 1'b0;
                        if (!chan_ok_reg || meta_cnt == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            // first read: oldest slot
                            ent_rd_en   = 1'b1;
                            ent_rd_addr = base_reg + ADDR_W'(meta_old);
                            ptr_next    = ptr_inc(meta_old);
                            cnt_next    = meta_cnt;
                            iss_next    = CNT_W'(1);
                            proc_next   = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // keep one read in flight ahead of the compare
                if (iss_reg != cnt_reg)
                begin
                    ent_rd_en = 1'b1;
                    ptr_next  = ptr_inc(ptr_reg);
                    iss_next  = iss_reg + 1'b1;
                end
                // oldest to newest; first exact hit freezes the choice
                if (!exact_reg)
                begin
                    if (ent_rd_data.frame_num == fid_reg)
                    begin
                        exact_next = 1'b1;
                        have_next  = 1'b1;
                        best_next  = ent_rd_data;
                    end
                    else if (ent_rd_data.frame_num < fid_reg &&
                             (!have_reg || ent_rd_data.frame_num > best_reg.frame_num))
                    begin
                        have_next = 1'b1;
                        best_next = ent_rd_data;
                    end
                end
                if (proc_reg == cnt_reg - 1'b1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    proc_next = proc_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = fin_found;
                    hit_next       = fin_found ? best_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            md_reg        <= CNT_W'(DEPTH);
            gap_reg       <= GAP_W'(1);
            have_reg      <= 1'b0;
            exact_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            md_reg        <= md_next;
            gap_reg       <= gap_next;
            have_reg      <= have_next;
            exact_reg     <= exact_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg      <= kind;
            chan_ok_reg   <= chan_ok_in;
            img_valid_reg <= image_valid;
            chan_reg      <= chan_idx_in;
            base_reg      <= ADDR_W'(chan_idx_in) * ADDR_W'(DEPTH);
            fid_reg       <= frame_num;
            ts_reg        <= capture_time;
            handle_reg    <= image_handle;
        end
        cnt_reg   <= cnt_next;
        iss_reg   <= iss_next;
        proc_reg  <= proc_next;
        ptr_reg   <= ptr_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        hit_reg   <= hit_next;
    end

    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign hit_frame_num    = hit_reg.frame_num;
    assign hit_capture_time = hit_reg.capture_time;
    assign hit_image_handle = hit_reg.image_handle;

    // a result only appears from the final lookup step
    `FHNL_ASSERT_IMP(a_result_from_fin, $rose(out_valid_reg), $past(state_reg == S_FIN))
    // trimmed history never exceeds the depth limit and is never empty
    `FHNL_ASSERT_IMP(a_trim_bounds, meta_wr_en, (meta_wr_cnt <= md_reg) && (meta_wr_cnt != '0))
    // reads issued and entries compared stay within the live count
    `FHNL_ASSERT_IMP(a_scan_bounds, state_reg == S_SCAN, (iss_reg <= cnt_reg) && (proc_reg < cnt_reg))
    // every accepted transaction goes through the metadata read
    `FHNL_ASSERT_NXT(a_accept_meta, in_accept, state_reg == S_META)

endmodule

`default_nettype wire

// ===== tb/frame_history_nearest_lookup_unit_test.sv =====
`timescale 1ns / 1ps

// Directed table first, then six random phases with different register settings.
// Every lookup transaction is predicted when it is accepted. The monitor takes
// the oldest prediction for each result transaction and compares it field by field.
module frame_history_nearest_lookup_unit_test;
    import fhnl_pkg::*;

    localparam int NCH          = NUM_CHANNELS_DEF;
    localparam int DEP          = DEPTH_DEF;
    localparam int STALL_LIMIT  = 3000;   // cycles with no transaction on either side
    localparam int DRAIN_PAUSE  = 16;     // wait after the last result for a trailing store
    localparam int HOLDOFF_LEN  = 400;
    localparam int PHASE_ITEMS  = 100;

    localparam logic [FRAME_ID_W-1:0] ID_MAX     = '1;
    localparam logic [TS_W-1:0]       TS_MAX     = '1;
    localparam logic [HANDLE_W-1:0]   HANDLE_MAX = '1;

    typedef struct packed {
        logic                  found;
        logic [FRAME_ID_W-1:0] fid;
        logic [TS_W-1:0]       ts;
        logic [HANDLE_W-1:0]   handle;
    } lookup_result_t;

    localparam lookup_result_t MISS = '0;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

    // one line of the directed table; random items use the same shape
    typedef struct packed {
        row_op_t               op;
        logic                  kind;
        logic [CHAN_W-1:0]     channel;
        logic [FRAME_ID_W-1:0] fid;
        logic [TS_W-1:0]       ts;
        logic [HANDLE_W-1:0]   handle;
        logic                  img_valid;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  has_want;   // result typed into the table
        lookup_result_t        want;
    } stim_row_t;

    // ---------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ---------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  kind         = KIND_STORE;
    logic [CHAN_W-1:0]     channel      = '0;
    logic [FRAME_ID_W-1:0] frame_num    = '0;
    logic [TS_W-1:0]       capture_time = '0;
    logic [HANDLE_W-1:0]   image_handle = '0;
    logic                  image_valid  = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  found;
    logic [FRAME_ID_W-1:0] hit_frame_num;
    logic [TS_W-1:0]       hit_capture_time;
    logic [HANDLE_W-1:0]   hit_image_handle;

    frame_history_nearest_lookup_unit DUT (.*);

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // Shadow of the per-channel frame rings and the two registers
    // ---------------------------------------------------------------------
    logic [FRAME_ID_W-1:0] hist_fid    [NCH][DEP];
    logic [TS_W-1:0]       hist_ts     [NCH][DEP];
    logic [HANDLE_W-1:0]   hist_handle [NCH][DEP];
    int                    hist_count  [NCH] = '{default: 0};
    int                    hist_oldest [NCH] = '{default: 0};
    int                    depth_cap   = DEP;
    logic [GAP_W-1:0]      gap_cap     = 32'd1;

    lookup_result_t        expected_lookups [$];
    stim_row_t             script [$];
    logic [FRAME_ID_W-1:0] recent_id [NCH] = '{default: '0};

    int errors       = 0;
    int quiet_cycles = 0;
    int holdoff_left = 0;
    bit calm         = 1'b0;   // no idling on either side while set

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_DEPTH_LIMIT) begin
            // only the low nibble counts; zero means one, above DEPTH clamps
            depth_cap = int'(val[MD_W-1:0]);
            if (depth_cap == 0)
                depth_cap = 1;
            if (depth_cap > DEP)
                depth_cap = DEP;
        end
        else if (idx == REG_GAP_LIMIT) begin
            gap_cap = (val[GAP_W-1:0] == '0) ? 32'd1 : val[GAP_W-1:0];
        end
    endfunction

    function automatic void drop_oldest_frame(input logic [CHAN_W-1:0] ch);
        hist_oldest[ch] = (hist_oldest[ch] + 1) % DEP;
        hist_count[ch]  = hist_count[ch] - 1;
    endfunction

    function automatic void history_store(input logic [CHAN_W-1:0] ch,
                                          input logic [FRAME_ID_W-1:0] fid,
                                          input logic [TS_W-1:0] ts,
                                          input logic [HANDLE_W-1:0] handle);
        int slot;
        if (hist_count[ch] >= DEP)
            drop_oldest_frame(ch);
        slot = (hist_oldest[ch] + hist_count[ch]) % DEP;
        hist_fid[ch][slot]    = fid;
        hist_ts[ch][slot]     = ts;
        hist_handle[ch][slot] = handle;
        hist_count[ch]        = hist_count[ch] + 1;
        // a lowered depth limit only takes hold here
        while (hist_count[ch] > depth_cap)
            drop_oldest_frame(ch);
    endfunction

    function automatic lookup_result_t hit(input logic [FRAME_ID_W-1:0] fid,
                                           input logic [TS_W-1:0] ts,
                                           input logic [HANDLE_W-1:0] handle);
        lookup_result_t r;
        r = '{1'b1, fid, ts, handle};
        return r;
    endfunction

    // exact id wins; else largest id not above target, oldest on a tie,
    // and only if within gap_cap of the target
    function automatic lookup_result_t nearest_frame(input logic [CHAN_W-1:0] ch,
                                                     input logic [FRAME_ID_W-1:0] target);
        lookup_result_t r;
        int             s;
        int             best;
        bit             have;
        bit             exact;
        r     = MISS;
        have  = 1'b0;
        exact = 1'b0;
        best  = 0;
        for (int i = 0; i < hist_count[ch] && !exact; i++) begin
            s = (hist_oldest[ch] + i) % DEP;
            if (hist_fid[ch][s] == target) begin
                exact = 1'b1;
                have  = 1'b1;
                best  = s;
            end
            else if (hist_fid[ch][s] <= target
                     && (!have || hist_fid[ch][s] > hist_fid[ch][best])) begin
                have = 1'b1;
                best = s;
            end
        end
        if (have && (exact || target - hist_fid[ch][best] <= {16'd0, gap_cap}))
            r = hit(hist_fid[ch][best], hist_ts[ch][best], hist_handle[ch][best]);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Directed table builders
    // ---------------------------------------------------------------------
    function automatic void add_item(input logic k, input logic [CHAN_W-1:0] ch,
                                     input logic [FRAME_ID_W-1:0] fid,
                                     input logic [TS_W-1:0] ts,
                                     input logic [HANDLE_W-1:0] handle,
                                     input logic img_valid);
        stim_row_t r;
        r           = '0;
        r.op        = ROW_ITEM;
        r.kind      = k;
        r.channel   = ch;
        r.fid       = fid;
        r.ts        = ts;
        r.handle    = handle;
        r.img_valid = img_valid;
        script      = {script, r};
    endfunction

    // lookup whose answer is plain from the table itself
    function automatic void add_check(input logic [CHAN_W-1:0] ch,
                                      input logic [FRAME_ID_W-1:0] target,
                                      input lookup_result_t want);
        stim_row_t r;
        r          = '0;
        r.op       = ROW_ITEM;
        r.kind     = KIND_LOOKUP;
        r.channel  = ch;
        r.fid      = target;
        r.has_want = 1'b1;
        r.want     = want;
        script     = {script, r};
    endfunction

    function automatic void add_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.op      = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        script    = {script, r};
    endfunction

    function automatic logic [47:0] random_id48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // Mostly a video-like stream per channel: stores step the id by 0..3
    // (0 gives duplicate ids for tie cases), lookups aim just around the
    // newest id. About one item in seven is pure noise.
    function automatic stim_row_t random_frame_item();
        stim_row_t r;
        bit        noise;
        r           = '0;
        r.op        = ROW_ITEM;
        r.kind      = ($urandom_range(0, 1) != 0) ? KIND_LOOKUP : KIND_STORE;
        r.channel   = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, NCH - 1))
                                                  : CHAN_W'($urandom_range(0, 3));
        r.ts        = random_id48();
        r.handle    = $urandom;
        r.img_valid = ($urandom_range(0, 9) != 0);
        noise       = ($urandom_range(0, 99) < 15);
        if (r.kind == KIND_STORE) begin
            r.fid = noise ? random_id48()
                          : recent_id[r.channel] + 48'($urandom_range(0, 3));
            if (r.img_valid)
                recent_id[r.channel] = r.fid;
        end
        else begin
            r.fid = noise ? random_id48()
                          : recent_id[r.channel] - 48'($urandom_range(0, 10))
                            + 48'($urandom_range(0, 3));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    task automatic send(input stim_row_t r);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 11)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind         <= r.kind;
        channel      <= r.channel;
        frame_num    <= r.fid;
        capture_time <= r.ts;
        image_handle <= r.handle;
        image_valid  <= r.img_valid;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transaction taken at this edge: update the shadow in order
        if (r.kind == KIND_STORE) begin
            if (r.img_valid)
                history_store(r.channel, r.fid, r.ts, r.handle);
        end
        else begin
            expected_lookups = {expected_lookups,
                                r.has_want ? r.want : nearest_frame(r.channel, r.fid)};
        end
        @(negedge clk);
    endtask

    // Stop offering, wait for every result, then let a trailing store finish.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        apply_setting(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: random stalls, plus the long hold-off counted here
    // ---------------------------------------------------------------------
    initial begin : receiver
        forever begin
            @(negedge clk);
            if (holdoff_left > 0) begin
                out_ready    <= 1'b0;
                holdoff_left  = holdoff_left - 1;
            end
            else begin
                out_ready <= calm || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------
    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors = errors + 1;
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin : result_monitor
        lookup_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_lookups.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result, expected none, got found=%b id=%h ts=%h h=%h",
                         $time, found, hit_frame_num, hit_capture_time, hit_image_handle);
            end
            else begin
                want = expected_lookups[0];
                expected_lookups.delete(0);
                check_field("found", 64'(want.found), 64'(found));
                check_field("hit_frame_num", 64'(want.fid), 64'(hit_frame_num));
                check_field("hit_capture_time", 64'(want.ts), 64'(hit_capture_time));
                check_field("hit_image_handle", 64'(want.handle), 64'(hit_image_handle));
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no transaction.
    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t row;
        int        useful;

        // directed table; registers are at reset: depth 8, gap 1
        add_check(4'd0, 48'd0, MISS);                              // empty after reset
        add_item(KIND_STORE, 4'd0, 48'd10, 48'd100, 32'hA, 1'b1);
        add_item(KIND_STORE, 4'd0, 48'd20, 48'd200, 32'hB, 1'b0);  // no image, dropped
        add_check(4'd0, 48'd20, MISS);                             // 10 is 10 away
        add_check(4'd0, 48'd11, hit(48'd10, 48'd100, 32'hA));      // gap of exactly one
        add_item(KIND_STORE, 4'd15, ID_MAX, TS_MAX, HANDLE_MAX, 1'b1);
        add_item(KIND_STORE, 4'd15, 48'd0, 48'd0, 32'd0, 1'b1);
        add_check(4'd15, ID_MAX, hit(ID_MAX, TS_MAX, HANDLE_MAX));
        add_setting(REG_GAP_LIMIT, 32'd0);                         // zero acts as one
        add_check(4'd15, 48'd1, hit(48'd0, 48'd0, 32'd0));
        add_check(4'd0, 48'd12, MISS);
        add_setting(REG_GAP_LIMIT, 32'hFFFF_FFFF);
        add_check(4'd15, 48'hFFFF_FFFF, hit(48'd0, 48'd0, 32'd0));
        add_check(4'd15, 48'h1_0000_0000, MISS);                   // one past widest gap
        // ties: duplicate ids on channel 1
        add_item(KIND_STORE, 4'd1, 48'd5, 48'd51, 32'd1, 1'b1);
        add_item(KIND_STORE, 4'd1, 48'd5, 48'd52, 32'd2, 1'b1);
        add_item(KIND_STORE, 4'd1, 48'd3, 48'd31, 32'd3, 1'b1);
        add_item(KIND_STORE, 4'd1, 48'd3, 48'd32, 32'd4, 1'b1);
        add_item(KIND_LOOKUP, 4'd1, 48'd5, '0, '0, 1'b0);
        // fill the ring past DEPTH: first 5 falls out
        for (int i = 0; i < 5; i++)
            add_item(KIND_STORE, 4'd1, 48'(200 + i), 48'(2000 + i), 32'(16'h200 + i), 1'b1);
        add_item(KIND_LOOKUP, 4'd1, 48'd5, '0, '0, 1'b0);
        // lower depth: no trim until the next store on the channel
        add_setting(REG_DEPTH_LIMIT, 32'd3);
        add_item(KIND_LOOKUP, 4'd1, 48'd4, '0, '0, 1'b0);
        add_item(KIND_STORE, 4'd1, 48'd205, 48'd2005, 32'h205, 1'b1);
        add_check(4'd1, 48'd5, MISS);                              // only 203..205 left
        add_setting(REG_DEPTH_LIMIT, 32'hFFFF_FFF0);               // low nibble zero: one
        add_item(KIND_STORE, 4'd1, 48'd7, 48'd70, 32'h7, 1'b1);
        add_item(KIND_LOOKUP, 4'd1, 48'd204, '0, '0, 1'b0);
        add_setting(REG_DEPTH_LIMIT, 32'd15);                      // clamps to DEPTH

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].op == ROW_CFG) begin
                settle_idle();
                write_register(script[i].reg_idx, script[i].reg_val);
            end
            else begin
                send(script[i]);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            settle_idle();
            case (phase)
                0: write_register(REG_GAP_LIMIT, 32'd4);   // depth stays clamped to 8
                1: begin
                    write_register(REG_DEPTH_LIMIT, 32'd1);
                    write_register(REG_GAP_LIMIT, 32'hFFFF_FFFF);
                end
                2: begin
                    write_register(REG_DEPTH_LIMIT, 32'($urandom_range(2, 7)));
                    write_register(REG_GAP_LIMIT, 32'($urandom_range(1, 64)));
                end
                3: begin
                    write_register(REG_DEPTH_LIMIT, $urandom);   // any nibble
                    write_register(REG_GAP_LIMIT, $urandom);
                end
                4: begin
                    write_register(REG_DEPTH_LIMIT, 32'd8);
                    write_register(REG_GAP_LIMIT, 32'd0);
                end
                default: begin
                    write_register(REG_DEPTH_LIMIT, 32'($urandom_range(1, 8)));
                    write_register(REG_GAP_LIMIT, 32'($urandom_range(1, 16)));
                end
            endcase
            calm   = (phase == 1);
            useful = 0;
            while (useful < PHASE_ITEMS) begin
                // receiver blocks for a long stretch; sender keeps pushing
                if (phase == 2 && useful == 40 && holdoff_left == 0)
                    holdoff_left = HOLDOFF_LEN;
                // sender stops until all results are back
                if (phase == 3 && useful == 50)
                    settle_idle();
                row = random_frame_item();
                send(row);
                if (row.kind == KIND_LOOKUP || row.img_valid)
                    useful = useful + 1;
            end
        end
        calm = 1'b0;

        settle_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
